// ----- rtl/sample_index_utc_timebase_unit_defines.svh -----
// assertion macros shared by the checker
`ifndef SAMPLE_INDEX_UTC_TIMEBASE_UNIT_DEFINES_SVH
`define SAMPLE_INDEX_UTC_TIMEBASE_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SIUT_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("siut check failed");

// next-cycle implication, sampled on clk, off during reset
`define SIUT_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("siut check failed");

`endif

// ----- rtl/siut_pkg.sv -----
`default_nettype none
package siut_pkg;
	// nanoseconds per second, fits in 30 bits
	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

	// op codes
	localparam logic OP_SYNC  = 1'b0;
	localparam logic OP_LABEL = 1'b1;

	// register indexes
	localparam logic CFG_STALENESS = 1'b0;
	localparam logic CFG_BACKWARD  = 1'b1;

	// time quality codes
	localparam logic [1:0] QUAL_UNSYNC   = 2'd0;
	localparam logic [1:0] QUAL_HOLDOVER = 2'd1;
	localparam logic [1:0] QUAL_SYNC     = 2'd2;

	// classified word passed from front to back
	typedef struct packed {
		logic        calc;
		logic        neg;
		logic [63:0] mag;
		logic [31:0] rate;
		logic [63:0] utc;
		logic [62:0] unc;
		logic [1:0]  quality;
	} entry_t;
endpackage
`default_nettype wire

// ----- rtl/siut_queue.sv -----
`default_nettype none
module siut_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  siut_pkg::entry_t     push_data,
	output logic                 full,
	input  wire logic            pop,
	output siut_pkg::entry_t     pop_data,
	output logic                 empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	siut_pkg::entry_t mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem[rd_ptr_q];

	// storage write
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/siut_front.sv -----
`default_nettype none
module siut_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [62:0] now_ns,
	input  wire logic        sync_utc_locked,
	input  wire logic [63:0] sync_sample_count,
	input  wire logic [31:0] sync_rate_hz,
	input  wire logic [31:0] sync_generation,
	input  wire logic signed [63:0] sync_utc_ns,
	input  wire logic [62:0] sync_uncertainty_ns,
	input  wire logic [63:0] sample_idx,
	input  wire logic [31:0] sample_generation,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [62:0] cfg_data,
	input  wire logic        q_full,
	output logic             push,
	output siut_pkg::entry_t push_data
);
	typedef enum logic [1:0] {F_IDLE, F_EVAL, F_PUSH} fstate_t;

	fstate_t state_q;
	logic accept;

	// item capture
	logic        op_s1, locked_s1;
	logic [62:0] now_s1, unc_s1;
	logic [63:0] count_s1, idx_s1, utc_s1;
	logic [31:0] rate_s1, gen_s1, sgen_s1;

	// held sync point and registers
	logic        have_sync_q, held_locked_q;
	logic [63:0] held_count_q, held_utc_q;
	logic [31:0] held_rate_q, held_gen_q;
	logic [62:0] held_unc_q, arrival_q;
	logic [62:0] stale_thr_q;
	logic [15:0] max_back_q;

	// evaluation results
	logic [1:0]  quality_s2;
	logic        base_ok_s2, behind_s2_lt;
	logic [63:0] behind_s2, delta_s2;
	logic [47:0] limit_s2;

	logic        stale;
	logic [62:0] age;
	logic        ok;

	assign accept = start && !busy;
	assign busy   = (state_q != F_IDLE);
	assign age    = now_s1 - arrival_q;
	assign stale  = (now_s1 > arrival_q) && (age > stale_thr_q);

	// final check and entry build
	always_comb begin
		ok = base_ok_s2 && !(behind_s2_lt && (behind_s2 > {16'b0, limit_s2}));
		push_data.calc    = ok;
		push_data.neg     = delta_s2[63];
		push_data.mag     = delta_s2[63] ? (64'd0 - delta_s2) : delta_s2;
		push_data.rate    = held_rate_q;
		push_data.utc     = held_utc_q;
		push_data.unc     = held_unc_q;
		push_data.quality = quality_s2;
		push = (state_q == F_PUSH);
	end

	// item capture registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= op;
			now_s1    <= now_ns;
			locked_s1 <= sync_utc_locked;
			count_s1  <= sync_sample_count;
			rate_s1   <= sync_rate_hz;
			gen_s1    <= sync_generation;
			utc_s1    <= sync_utc_ns;
			unc_s1    <= sync_uncertainty_ns;
			idx_s1    <= sample_idx;
			sgen_s1   <= sample_generation;
		end
	end

	// sequencer, held state and evaluation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= F_IDLE;
			have_sync_q   <= 1'b0;
			held_locked_q <= 1'b0;
			held_count_q  <= '0;
			held_rate_q   <= '0;
			held_gen_q    <= '0;
			held_utc_q    <= '0;
			held_unc_q    <= '0;
			arrival_q     <= '0;
			stale_thr_q   <= 63'd1000000000;
			max_back_q    <= 16'd10;
			quality_s2    <= siut_pkg::QUAL_UNSYNC;
			base_ok_s2    <= 1'b0;
			behind_s2_lt  <= 1'b0;
			behind_s2     <= '0;
			delta_s2      <= '0;
			limit_s2      <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					siut_pkg::CFG_STALENESS: stale_thr_q <= cfg_data;
					siut_pkg::CFG_BACKWARD:  max_back_q  <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_EVAL;
					end
				end
				F_EVAL: begin
					state_q      <= F_PUSH;
					limit_s2     <= 48'(held_rate_q) * 48'(max_back_q);
					behind_s2    <= held_count_q - idx_s1;
					behind_s2_lt <= idx_s1 < held_count_q;
					delta_s2     <= idx_s1 - held_count_q;
					if (op_s1 == siut_pkg::OP_SYNC) begin
						have_sync_q   <= 1'b1;
						held_locked_q <= locked_s1;
						held_count_q  <= count_s1;
						held_rate_q   <= rate_s1;
						held_gen_q    <= gen_s1;
						held_utc_q    <= utc_s1;
						held_unc_q    <= unc_s1;
						arrival_q     <= now_s1;
						base_ok_s2    <= 1'b0;
						quality_s2    <= locked_s1 ? siut_pkg::QUAL_SYNC
						                           : siut_pkg::QUAL_UNSYNC;
					end else begin
						base_ok_s2 <= have_sync_q && held_locked_q &&
						              (held_rate_q != '0) && (sgen_s1 == held_gen_q);
						if (!have_sync_q || !held_locked_q) begin
							quality_s2 <= siut_pkg::QUAL_UNSYNC;
						end else if (stale) begin
							quality_s2 <= siut_pkg::QUAL_HOLDOVER;
						end else begin
							quality_s2 <= siut_pkg::QUAL_SYNC;
						end
					end
				end
				F_PUSH: begin
					if (!q_full) begin
						state_q <= F_IDLE;
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/siut_back.sv -----
`default_nettype none
module siut_back (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  siut_pkg::entry_t q_data,
	output logic             pop,
	output logic             done,
	output logic             estimate_valid,
	output logic signed [63:0] utc_estimate_ns,
	output logic [62:0]      uncertainty_out_ns,
	output logic [1:0]       time_quality
);
	typedef enum logic [2:0] {
		B_IDLE, B_DIV1, B_MQL, B_MQH, B_MR, B_DIV2, B_ADD, B_FIN
	} bstate_t;

	bstate_t state_q;
	siut_pkg::entry_t ent_q;
	logic [31:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] acc_q;
	logic [5:0]  cnt_q;

	logic [32:0] shifted;
	logic        ge;
	logic [31:0] rem_next;
	logic [63:0] dvd_next;
	logic [61:0] frac_prod;

	assign pop = (state_q == B_IDLE) && !q_empty;

	// one restoring division step
	always_comb begin
		shifted   = {rem_q, dvd_q[63]};
		ge        = shifted >= {1'b0, ent_q.rate};
		rem_next  = ge ? 32'(shifted - {1'b0, ent_q.rate}) : shifted[31:0];
		dvd_next  = {dvd_q[62:0], ge};
		frac_prod = 62'(rem_q) * 62'(siut_pkg::NS_PER_SEC);
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q            <= B_IDLE;
			done               <= 1'b0;
			estimate_valid     <= 1'b0;
			utc_estimate_ns    <= '0;
			uncertainty_out_ns <= '0;
			time_quality       <= siut_pkg::QUAL_UNSYNC;
		end else begin
			done <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						if (q_data.calc) begin
							state_q <= B_DIV1;
						end else begin
							done               <= 1'b1;
							estimate_valid     <= 1'b0;
							utc_estimate_ns    <= '0;
							uncertainty_out_ns <= '0;
							time_quality       <= q_data.quality;
						end
					end
				end
				B_DIV1: begin
					if (cnt_q == '0) begin
						state_q <= B_MQL;
					end
				end
				B_MQL: state_q <= B_MQH;
				B_MQH: state_q <= B_MR;
				B_MR:  state_q <= B_DIV2;
				B_DIV2: begin
					if (cnt_q == '0) begin
						state_q <= B_ADD;
					end
				end
				B_ADD: state_q <= B_FIN;
				B_FIN: begin
					state_q            <= B_IDLE;
					done               <= 1'b1;
					estimate_valid     <= 1'b1;
					utc_estimate_ns    <= ent_q.neg ? (ent_q.utc - acc_q) : (ent_q.utc + acc_q);
					uncertainty_out_ns <= ent_q.unc;
					time_quality       <= ent_q.quality;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// datapath: divider, partial products, accumulator
	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				ent_q <= q_data;
				rem_q <= '0;
				dvd_q <= q_data.mag;
				cnt_q <= 6'd63;
			end
			B_DIV1, B_DIV2: begin
				rem_q <= rem_next;
				dvd_q <= dvd_next;
				cnt_q <= cnt_q - 1'b1;
			end
			B_MQL: begin
				acc_q <= 64'(dvd_q[31:0]) * 64'(siut_pkg::NS_PER_SEC);
			end
			B_MQH: begin
				acc_q <= acc_q + {32'(dvd_q[63:32] * 32'(siut_pkg::NS_PER_SEC)), 32'b0};
			end
			B_MR: begin
				// remainder times 1e9 is below rate << 30, so 30 steps suffice
				rem_q <= frac_prod[61:30];
				dvd_q <= {frac_prod[29:0], 34'b0};
				cnt_q <= 6'd29;
			end
			B_ADD: begin
				acc_q <= acc_q + {34'b0, dvd_q[29:0]};
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ----- rtl/sample_index_utc_timebase_unit.sv -----
// flow: each word is captured, evaluated and pushed into the queue; op 0 and
// rejected op 1 words are then reported by the back end straight from idle,
// labelled op 1 words after 64 and 30 divider steps; the front takes no new word
// until the last is pushed, waits while the queue is full; labels are paced by the divider
// reset (arst_n low): no sync held, registers at 1e9 ns and 10 s; done is
// a one-cycle strobe and cannot be stalled by the receiver
`default_nettype none
module sample_index_utc_timebase_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        op,
	input  wire logic [62:0] now_ns,
	input  wire logic        sync_utc_locked,
	input  wire logic [63:0] sync_sample_count,
	input  wire logic [31:0] sync_rate_hz,
	input  wire logic [31:0] sync_generation,
	input  wire logic signed [63:0] sync_utc_ns,
	input  wire logic [62:0] sync_uncertainty_ns,
	input  wire logic [63:0] sample_idx,
	input  wire logic [31:0] sample_generation,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [62:0] cfg_data,
	output logic             done,
	output logic             estimate_valid,
	output logic signed [63:0] utc_estimate_ns,
	output logic [62:0]      uncertainty_out_ns,
	output logic [1:0]       time_quality
);
	siut_pkg::entry_t push_data, pop_data;
	logic push, pop, q_full, q_empty;

	// front: capture, held state, classification
	siut_front u_front (
		.clk, .arst_n, .start, .busy, .op, .now_ns, .sync_utc_locked,
		.sync_sample_count, .sync_rate_hz, .sync_generation, .sync_utc_ns,
		.sync_uncertainty_ns, .sample_idx, .sample_generation,
		.cfg_write, .cfg_index, .cfg_data,
		.q_full, .push, .push_data
	);

	// word queue between the two halves
	siut_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n, .push, .push_data, .full(q_full),
		.pop, .pop_data, .empty(q_empty)
	);

	// back: division and extrapolation
	siut_back u_back (
		.clk, .arst_n, .q_empty, .q_data(pop_data), .pop,
		.done, .estimate_valid, .utc_estimate_ns, .uncertainty_out_ns, .time_quality
	);
endmodule
`default_nettype wire

// ----- rtl/siut_checker.sv -----
`default_nettype none
`include "sample_index_utc_timebase_unit_defines.svh"
module siut_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic        estimate_valid,
	input wire logic [63:0] utc_estimate_ns,
	input wire logic [62:0] uncertainty_out_ns,
	input wire logic [1:0]  time_quality
);
	// an accepted word keeps the front busy next cycle
	`SIUT_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	// a word without a label carries zeros
	`SIUT_ASSERT_IMP(a_invalid_zero, done && !estimate_valid, utc_estimate_ns == '0 && uncertainty_out_ns == '0)
	// a label needs a locked sync
	`SIUT_ASSERT_IMP(a_valid_locked, done && estimate_valid, time_quality != 2'd0)
	// quality code stays in range
	`SIUT_ASSERT_IMP(a_quality_range, done, time_quality != 2'd3)
endmodule
`default_nettype wire

bind sample_index_utc_timebase_unit siut_checker u_siut_checker (.*);
